// File: sv/assert_macros.svh
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// general property, sampled on clk, off while rst_n is low
`define AART_CHECK(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// a stalled response keeps the given field
`define AART_HOLD(label, sig, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) \
        rsp_valid && rsp_stall |=> $stable(sig)) else $error(msg);

`endif

// File: sv/aart_pkg.sv
// shared types, constants and latencies of the angle-axis transform pipeline
package aart_pkg;

    typedef logic signed [31:0] word_t;

    typedef struct packed {
        word_t x;
        word_t y;
        word_t z;
    } vec3_t;

    typedef struct packed {
        word_t w;
        word_t x;
        word_t y;
        word_t z;
    } quat_t;

    typedef struct packed {
        quat_t q;
        vec3_t p;
    } result_t;

    localparam int CORDIC_STAGES_DEF = 24;

    localparam int SQRT_STEPS = 32;
    localparam int SQRT_LAT   = SQRT_STEPS + 2;
    localparam int DIV_BITS   = 31;
    localparam int DIV_LAT    = DIV_BITS + 3;
    localparam int PLACE_LAT  = 5;

    localparam logic signed [35:0] PI_Q30      = 36'sd3373259426;
    localparam logic signed [35:0] HALF_PI_Q30 = 36'sd1686629713;
    localparam logic signed [35:0] TWO_PI_Q30  = 36'sd6746518852;
    localparam logic signed [33:0] GAIN_Q30    = 34'sd652032874;
    localparam logic signed [33:0] ONE_Q30     = 34'sd1073741824;

    // atan(2^-k) in Q.30
    function automatic logic [31:0] atan_q30(input int k);
        case (k)
            0:  return 32'd843314856;
            1:  return 32'd497837829;
            2:  return 32'd263043836;
            3:  return 32'd133525158;
            4:  return 32'd67021686;
            5:  return 32'd33543515;
            6:  return 32'd16775850;
            7:  return 32'd8388437;
            8:  return 32'd4194282;
            9:  return 32'd2097149;
            10: return 32'd1048575;
            11: return 32'd524287;
            12: return 32'd262143;
            13: return 32'd131071;
            14: return 32'd65535;
            15: return 32'd32767;
            16: return 32'd16383;
            17: return 32'd8191;
            18: return 32'd4095;
            19: return 32'd2047;
            20: return 32'd1023;
            21: return 32'd511;
            22: return 32'd255;
            23: return 32'd127;
            24: return 32'd63;
            25: return 32'd31;
            26: return 32'd15;
            27: return 32'd8;
            28: return 32'd4;
            29: return 32'd2;
            30: return 32'd1;
            default: return 32'd0;
        endcase
    endfunction

endpackage

// File: sv/aart_delay.sv
// enabled shift line that keeps side data aligned with the pipeline
module aart_delay import aart_pkg::*; #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1
) (
    input  logic             clk,
    input  logic             en,
    input  logic [WIDTH-1:0] din,
    output logic [WIDTH-1:0] dout
);

    logic [WIDTH-1:0] tap_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            tap_reg[0] <= din;
            for (int i = 1; i < DEPTH; i++)
            begin
                tap_reg[i] <= tap_reg[i-1];
            end
        end
    end

    assign dout = tap_reg[DEPTH-1];

endmodule

// File: sv/aart_isqrt.sv
// squared length of the rotation vector and its pipelined integer square root
module aart_isqrt import aart_pkg::*; (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        en,
    input  logic        in_valid,
    input  word_t       ax,
    input  word_t       ay,
    input  word_t       az,
    output logic        out_valid,
    output logic [31:0] root
);

    logic [SQRT_LAT-1:0] vld_reg;
    logic [SQRT_LAT-1:0] vld_next;

    assign vld_next = {vld_reg[SQRT_LAT-2:0], in_valid};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= vld_next;
        end
    end

    logic signed [63:0] sqx_full, sqy_full, sqz_full;
    logic [62:0] sqx_reg, sqy_reg, sqz_reg;
    logic [63:0] sum_reg, sum_next;

    assign sqx_full = ax * ax;
    assign sqy_full = ay * ay;
    assign sqz_full = az * az;
    assign sum_next = {1'b0, sqx_reg} + {1'b0, sqy_reg} + {1'b0, sqz_reg};

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sqx_reg <= sqx_full[62:0];
            sqy_reg <= sqy_full[62:0];
            sqz_reg <= sqz_full[62:0];
            sum_reg <= sum_next;
        end
    end

    // one root bit per stage, radicand bits enter two at a time from the top
    logic [63:0] v_reg    [SQRT_STEPS];
    logic [35:0] rem_reg  [SQRT_STEPS];
    logic [31:0] root_reg [SQRT_STEPS];

    for (genvar j = 0; j < SQRT_STEPS; j++)
    begin : g_step
        logic [63:0] v_in, v_next;
        logic [35:0] rem_in, rem_next, r2, trial;
        logic [31:0] root_in, root_next;

        if (j == 0)
        begin : g_first
            assign v_in    = sum_reg;
            assign rem_in  = '0;
            assign root_in = '0;
        end
        else
        begin : g_rest
            assign v_in    = v_reg[j-1];
            assign rem_in  = rem_reg[j-1];
            assign root_in = root_reg[j-1];
        end

        always_comb
        begin
            r2     = {rem_in[33:0], v_in[63:62]};
            trial  = {2'b00, root_in, 2'b01};
            v_next = {v_in[61:0], 2'b00};
            if (r2 >= trial)
            begin
                rem_next  = r2 - trial;
                root_next = {root_in[30:0], 1'b1};
            end
            else
            begin
                rem_next  = r2;
                root_next = {root_in[30:0], 1'b0};
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                v_reg[j]    <= v_next;
                rem_reg[j]  <= rem_next;
                root_reg[j] <= root_next;
            end
        end
    end

    assign root      = root_reg[SQRT_STEPS-1];
    assign out_valid = vld_reg[SQRT_LAT-1];

endmodule

// File: sv/aart_cordic.sv
// half-angle range reduction and pipelined rotation-mode cordic for cos and sin
module aart_cordic import aart_pkg::*; #(
    parameter int STAGES = CORDIC_STAGES_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        en,
    input  logic        in_valid,
    input  logic [31:0] len,
    output logic        out_valid,
    output word_t       cos_q,
    output word_t       sin_q
);

    localparam int LAT = STAGES + 2;

    logic [LAT-1:0] vld_reg;
    logic [LAT-1:0] vld_next;

    assign vld_next = {vld_reg[LAT-2:0], in_valid};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= vld_next;
        end
    end

    logic signed [33:0] x_reg [STAGES+1];
    logic signed [33:0] y_reg [STAGES+1];
    logic signed [33:0] z_reg [STAGES+1];
    logic               neg_reg [STAGES+1];

    // theta = 2*len, wrapped above pi, then folded into +-pi/2
    logic signed [35:0] theta, th1, z_next;
    logic               neg_next;

    always_comb
    begin
        theta = $signed({3'b000, len, 1'b0});
        th1   = (theta > PI_Q30) ? theta - TWO_PI_Q30 : theta;
        if (th1 > HALF_PI_Q30)
        begin
            z_next   = th1 - PI_Q30;
            neg_next = 1'b1;
        end
        else if (th1 < -HALF_PI_Q30)
        begin
            z_next   = th1 + PI_Q30;
            neg_next = 1'b1;
        end
        else
        begin
            z_next   = th1;
            neg_next = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg[0]   <= GAIN_Q30;
            y_reg[0]   <= '0;
            z_reg[0]   <= z_next[33:0];
            neg_reg[0] <= neg_next;
        end
    end

    for (genvar i = 0; i < STAGES; i++)
    begin : g_iter
        localparam int K = i;
        logic signed [33:0] dx, dy, ang, x_next, y_next, zi_next;

        assign dx  = y_reg[i] >>> K;
        assign dy  = x_reg[i] >>> K;
        assign ang = $signed({2'b00, atan_q30(K)});

        always_comb
        begin
            if (z_reg[i] >= 0)
            begin
                x_next  = x_reg[i] - dx;
                y_next  = y_reg[i] + dy;
                zi_next = z_reg[i] - ang;
            end
            else
            begin
                x_next  = x_reg[i] + dx;
                y_next  = y_reg[i] - dy;
                zi_next = z_reg[i] + ang;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                x_reg[i+1]   <= x_next;
                y_reg[i+1]   <= y_next;
                z_reg[i+1]   <= zi_next;
                neg_reg[i+1] <= neg_reg[i];
            end
        end
    end

    function automatic word_t clamp_q30(input logic signed [33:0] v);
        logic signed [33:0] c;
        if (v > ONE_Q30)
        begin
            c = ONE_Q30;
        end
        else if (v < -ONE_Q30)
        begin
            c = -ONE_Q30;
        end
        else
        begin
            c = v;
        end
        return c[31:0];
    endfunction

    word_t cos_reg, sin_reg, cos_next, sin_next;

    assign cos_next = clamp_q30(neg_reg[STAGES] ? -x_reg[STAGES] : x_reg[STAGES]);
    assign sin_next = clamp_q30(neg_reg[STAGES] ? -y_reg[STAGES] : y_reg[STAGES]);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            cos_reg <= cos_next;
            sin_reg <= sin_next;
        end
    end

    assign cos_q     = cos_reg;
    assign sin_q     = sin_reg;
    assign out_valid = vld_reg[LAT-1];

endmodule

// File: sv/aart_vdiv.sv
// one quaternion vector part: |r|*|sin| / len, rounded, by a pipelined restoring divider
module aart_vdiv import aart_pkg::*; (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        en,
    input  logic        in_valid,
    input  word_t       r,
    input  word_t       sn,
    input  logic [31:0] len,
    output logic        out_valid,
    output word_t       q
);

    logic [DIV_LAT-1:0] vld_reg;
    logic [DIV_LAT-1:0] vld_next;

    assign vld_next = {vld_reg[DIV_LAT-2:0], in_valid};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= vld_next;
        end
    end

    logic [31:0] mr, sn_abs;
    logic [62:0] prod_next, prod_reg;
    logic [62:0] num_next, num_reg;
    logic [31:0] len_a_reg, len_b_reg;
    logic        sgn_a_reg, sgn_b_reg;

    assign mr        = r[31] ? ~r + 32'd1 : r;
    assign sn_abs    = sn[31] ? ~sn + 32'd1 : sn;
    assign prod_next = mr * sn_abs[30:0];
    // round to nearest: add half the divisor
    assign num_next  = prod_reg + {32'd0, len_a_reg[31:1]};

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg  <= prod_next;
            len_a_reg <= len;
            sgn_a_reg <= r[31] ^ sn[31];
            num_reg   <= num_next;
            len_b_reg <= len_a_reg;
            sgn_b_reg <= sgn_a_reg;
        end
    end

    // |r| <= len, so the quotient fits in DIV_BITS bits and the top half is below len
    logic [31:0]         rem_reg [DIV_BITS];
    logic [DIV_BITS-1:0] lo_reg  [DIV_BITS];
    logic [DIV_BITS-1:0] q_reg   [DIV_BITS];
    logic [31:0]         len_reg [DIV_BITS];
    logic                sgn_reg [DIV_BITS];

    for (genvar j = 0; j < DIV_BITS; j++)
    begin : g_div
        logic [31:0]         rem_in, rem_next, len_in;
        logic [DIV_BITS-1:0] lo_in, q_in, q_next;
        logic                sgn_in;
        logic [32:0]         t;

        if (j == 0)
        begin : g_first
            assign rem_in = num_reg[62:DIV_BITS];
            assign lo_in  = num_reg[DIV_BITS-1:0];
            assign q_in   = '0;
            assign len_in = len_b_reg;
            assign sgn_in = sgn_b_reg;
        end
        else
        begin : g_rest
            assign rem_in = rem_reg[j-1];
            assign lo_in  = lo_reg[j-1];
            assign q_in   = q_reg[j-1];
            assign len_in = len_reg[j-1];
            assign sgn_in = sgn_reg[j-1];
        end

        always_comb
        begin
            t = {rem_in, lo_in[DIV_BITS-1]};
            if (t >= {1'b0, len_in})
            begin
                rem_next = 32'(t - {1'b0, len_in});
                q_next   = {q_in[DIV_BITS-2:0], 1'b1};
            end
            else
            begin
                rem_next = t[31:0];
                q_next   = {q_in[DIV_BITS-2:0], 1'b0};
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[j] <= rem_next;
                lo_reg[j]  <= {lo_in[DIV_BITS-2:0], 1'b0};
                q_reg[j]   <= q_next;
                len_reg[j] <= len_in;
                sgn_reg[j] <= sgn_in;
            end
        end
    end

    logic [DIV_BITS-1:0] qc;
    word_t               mag, q_next_w, q_out_reg;

    always_comb
    begin
        qc  = (q_reg[DIV_BITS-1] > DIV_BITS'(ONE_Q30)) ? DIV_BITS'(ONE_Q30)
                                                        : q_reg[DIV_BITS-1];
        mag = $signed({1'b0, qc});
        // zero length: the rotation vector is all zero, so is the vector part
        if (len_reg[DIV_BITS-1] == 32'd0)
        begin
            q_next_w = '0;
        end
        else
        begin
            q_next_w = sgn_reg[DIV_BITS-1] ? -mag : mag;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            q_out_reg <= q_next_w;
        end
    end

    assign q         = q_out_reg;
    assign out_valid = vld_reg[DIV_LAT-1];

endmodule

// File: sv/aart_place.sv
// rotation matrix from the quaternion, point rotation and translation with saturation
module aart_place import aart_pkg::*; (
    input  logic  clk,
    input  logic  rst_n,
    input  logic  en,
    input  logic  in_valid,
    input  quat_t quat,
    input  vec3_t pnt,
    input  vec3_t shift,
    output logic  out_valid,
    output quat_t quat_out,
    output vec3_t world
);

    logic [PLACE_LAT-1:0] vld_reg;
    logic [PLACE_LAT-1:0] vld_next;

    assign vld_next = {vld_reg[PLACE_LAT-2:0], in_valid};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= vld_next;
        end
    end

    quat_t q_reg [PLACE_LAT];
    vec3_t p_reg [PLACE_LAT-1];
    vec3_t s_reg [PLACE_LAT-1];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            q_reg[0] <= quat;
            p_reg[0] <= pnt;
            s_reg[0] <= shift;
            for (int k = 1; k < PLACE_LAT; k++)
            begin
                q_reg[k] <= q_reg[k-1];
            end
            for (int k = 1; k < PLACE_LAT-1; k++)
            begin
                p_reg[k] <= p_reg[k-1];
                s_reg[k] <= s_reg[k-1];
            end
        end
    end

    function automatic logic signed [33:0] rnd64(input logic signed [63:0] v);
        logic signed [63:0] t;
        t = (v + 64'sd536870912) >>> 30;
        return t[33:0];
    endfunction

    function automatic logic signed [35:0] rnd66(input logic signed [65:0] v);
        logic signed [65:0] t;
        t = (v + 66'sd536870912) >>> 30;
        return t[35:0];
    endfunction

    // pair products: ab ac ad bb bc bd cc cd dd
    logic signed [63:0] t_reg [9];
    logic signed [63:0] t_next [9];

    always_comb
    begin
        t_next[0] = quat.w * quat.x;
        t_next[1] = quat.w * quat.y;
        t_next[2] = quat.w * quat.z;
        t_next[3] = quat.x * quat.x;
        t_next[4] = quat.x * quat.y;
        t_next[5] = quat.x * quat.z;
        t_next[6] = quat.y * quat.y;
        t_next[7] = quat.y * quat.z;
        t_next[8] = quat.z * quat.z;
    end

    logic signed [33:0] m_reg [9];
    logic signed [33:0] m_next [9];

    always_comb
    begin
        m_next[0] = rnd64(-t_reg[6] - t_reg[8]);
        m_next[1] = rnd64(t_reg[4] - t_reg[2]);
        m_next[2] = rnd64(t_reg[1] + t_reg[5]);
        m_next[3] = rnd64(t_reg[2] + t_reg[4]);
        m_next[4] = rnd64(-t_reg[3] - t_reg[8]);
        m_next[5] = rnd64(t_reg[7] - t_reg[0]);
        m_next[6] = rnd64(t_reg[5] - t_reg[1]);
        m_next[7] = rnd64(t_reg[0] + t_reg[7]);
        m_next[8] = rnd64(-t_reg[3] - t_reg[6]);
    end

    logic signed [65:0] pr_reg [9];
    logic signed [65:0] pr_next [9];
    word_t              pc [3];

    always_comb
    begin
        pc[0] = p_reg[1].x;
        pc[1] = p_reg[1].y;
        pc[2] = p_reg[1].z;
        for (int r = 0; r < 3; r++)
        begin
            for (int c = 0; c < 3; c++)
            begin
                pr_next[3*r+c] = m_reg[3*r+c] * pc[c];
            end
        end
    end

    logic signed [37:0] rs_reg [3];
    logic signed [37:0] rs_next [3];

    always_comb
    begin
        for (int r = 0; r < 3; r++)
        begin
            rs_next[r] = 38'(rnd66(pr_reg[3*r])) + 38'(rnd66(pr_reg[3*r+1]))
                       + 38'(rnd66(pr_reg[3*r+2]));
        end
    end

    word_t              self_c [3];
    word_t              sh_c [3];
    logic signed [39:0] tot [3];
    word_t              w_next [3];
    vec3_t              world_reg;

    always_comb
    begin
        self_c[0] = p_reg[3].x;
        self_c[1] = p_reg[3].y;
        self_c[2] = p_reg[3].z;
        sh_c[0]   = s_reg[3].x;
        sh_c[1]   = s_reg[3].y;
        sh_c[2]   = s_reg[3].z;
        for (int r = 0; r < 3; r++)
        begin
            tot[r] = (40'(rs_reg[r]) <<< 1) + 40'(self_c[r]) + 40'(sh_c[r]);
            if (tot[r] > 40'sd2147483647)
            begin
                w_next[r] = 32'sh7fffffff;
            end
            else if (tot[r] < -40'sd2147483648)
            begin
                w_next[r] = 32'sh80000000;
            end
            else
            begin
                w_next[r] = tot[r][31:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < 9; k++)
            begin
                t_reg[k]  <= t_next[k];
                m_reg[k]  <= m_next[k];
                pr_reg[k] <= pr_next[k];
            end
            for (int r = 0; r < 3; r++)
            begin
                rs_reg[r] <= rs_next[r];
            end
            world_reg.x <= w_next[0];
            world_reg.y <= w_next[1];
            world_reg.z <= w_next[2];
        end
    end

    assign world     = world_reg;
    assign quat_out  = q_reg[PLACE_LAT-1];
    assign out_valid = vld_reg[PLACE_LAT-1];

endmodule

// File: sv/angle_axis_rigid_transform.sv
// Places a model point by an angle-axis pose: takes one request per clock while req_stall is
// low and returns the quaternion (Q1.30) and the translated, rotated point (Q16.16, saturated).
// From an accepted request to rsp_valid the path runs through the squaring and sum registers,
// 32 square-root stages, the range fold, the cordic stages and its output stage, 34 divider
// stages for the vector parts, five stages of matrix and placement, and the output register.
// All stages advance together; a two-entry output buffer (output register plus skid entry)
// absorbs rsp_stall, and req_stall is raised only while both entries are full.
module angle_axis_rigid_transform import aart_pkg::*; #(
    parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
) (
    input  logic  clk,
    input  logic  rst_n,
    input  logic  req_valid,
    output logic  req_stall,
    input  word_t axis_angle_x,
    input  word_t axis_angle_y,
    input  word_t axis_angle_z,
    input  word_t shift_x,
    input  word_t shift_y,
    input  word_t shift_z,
    input  word_t local_x,
    input  word_t local_y,
    input  word_t local_z,
    output logic  rsp_valid,
    input  logic  rsp_stall,
    output word_t quat_w,
    output word_t quat_x,
    output word_t quat_y,
    output word_t quat_z,
    output word_t world_x,
    output word_t world_y,
    output word_t world_z
);

    localparam int CORDIC_LAT = CORDIC_STAGES + 2;
    localparam int ROT_LAT    = SQRT_LAT + CORDIC_LAT;
    localparam int PAY_LAT    = ROT_LAT + DIV_LAT;

    logic en;
    logic skid_valid_reg, skid_valid_next;
    logic out_valid_reg, out_valid_next;
    result_t skid_reg, skid_next, out_reg, out_next;

    assign en        = !skid_valid_reg;
    assign req_stall = skid_valid_reg;

    logic        sq_valid, cs_valid, vd_valid, pl_valid;
    logic [31:0] len, len_d;
    word_t       cos_q, sin_q, cos_d;
    vec3_t       rvec, rvec_d, vpart;
    vec3_t       pnt, pnt_d, shift, shift_d, world;
    quat_t       quat, quat_o;

    assign rvec  = '{x: axis_angle_x, y: axis_angle_y, z: axis_angle_z};
    assign pnt   = '{x: local_x, y: local_y, z: local_z};
    assign shift = '{x: shift_x, y: shift_y, z: shift_z};

    aart_isqrt u_isqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (req_valid),
        .ax        (axis_angle_x),
        .ay        (axis_angle_y),
        .az        (axis_angle_z),
        .out_valid (sq_valid),
        .root      (len)
    );

    aart_cordic #(
        .STAGES (CORDIC_STAGES)
    ) u_cordic (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (sq_valid),
        .len       (len),
        .out_valid (cs_valid),
        .cos_q     (cos_q),
        .sin_q     (sin_q)
    );

    aart_delay #(.WIDTH(32), .DEPTH(CORDIC_LAT)) u_len_dly (
        .clk (clk), .en (en), .din (len), .dout (len_d)
    );

    aart_delay #(.WIDTH($bits(vec3_t)), .DEPTH(ROT_LAT)) u_rvec_dly (
        .clk (clk), .en (en), .din (rvec), .dout (rvec_d)
    );

    aart_vdiv u_vdiv_x (
        .clk (clk), .rst_n (rst_n), .en (en), .in_valid (cs_valid),
        .r (rvec_d.x), .sn (sin_q), .len (len_d),
        .out_valid (vd_valid), .q (vpart.x)
    );

    aart_vdiv u_vdiv_y (
        .clk (clk), .rst_n (rst_n), .en (en), .in_valid (cs_valid),
        .r (rvec_d.y), .sn (sin_q), .len (len_d),
        .out_valid (), .q (vpart.y)
    );

    aart_vdiv u_vdiv_z (
        .clk (clk), .rst_n (rst_n), .en (en), .in_valid (cs_valid),
        .r (rvec_d.z), .sn (sin_q), .len (len_d),
        .out_valid (), .q (vpart.z)
    );

    aart_delay #(.WIDTH(32), .DEPTH(DIV_LAT)) u_cos_dly (
        .clk (clk), .en (en), .din (cos_q), .dout (cos_d)
    );

    aart_delay #(.WIDTH($bits(vec3_t)), .DEPTH(PAY_LAT)) u_pnt_dly (
        .clk (clk), .en (en), .din (pnt), .dout (pnt_d)
    );

    aart_delay #(.WIDTH($bits(vec3_t)), .DEPTH(PAY_LAT)) u_shift_dly (
        .clk (clk), .en (en), .din (shift), .dout (shift_d)
    );

    assign quat = '{w: cos_d, x: vpart.x, y: vpart.y, z: vpart.z};

    aart_place u_place (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (vd_valid),
        .quat      (quat),
        .pnt       (pnt_d),
        .shift     (shift_d),
        .out_valid (pl_valid),
        .quat_out  (quat_o),
        .world     (world)
    );

    // output register with one skid entry behind it
    logic    deliver, out_take;
    result_t pl_res;

    assign pl_res   = '{q: quat_o, p: world};
    assign deliver  = en && pl_valid;
    assign out_take = out_valid_reg && !rsp_stall;

    always_comb
    begin
        out_next        = out_reg;
        out_valid_next  = out_valid_reg;
        skid_next       = skid_reg;
        skid_valid_next = skid_valid_reg;
        if (!out_valid_reg || out_take)
        begin
            if (skid_valid_reg)
            begin
                out_next        = skid_reg;
                out_valid_next  = 1'b1;
                skid_valid_next = 1'b0;
            end
            else if (deliver)
            begin
                out_next       = pl_res;
                out_valid_next = 1'b1;
            end
            else
            begin
                out_valid_next = 1'b0;
            end
        end
        else if (deliver)
        begin
            skid_next       = pl_res;
            skid_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg  <= out_next;
        skid_reg <= skid_next;
    end

    assign rsp_valid = out_valid_reg;
    assign quat_w    = out_reg.q.w;
    assign quat_x    = out_reg.q.x;
    assign quat_y    = out_reg.q.y;
    assign quat_z    = out_reg.q.z;
    assign world_x   = out_reg.p.x;
    assign world_y   = out_reg.p.y;
    assign world_z   = out_reg.p.z;

endmodule

// File: sv/aart_checker.sv
// port-level checks of the transform block and their binding to it
`include "assert_macros.svh"

module aart_checker import aart_pkg::*; (
    input logic  clk,
    input logic  rst_n,
    input logic  req_stall,
    input logic  rsp_valid,
    input logic  rsp_stall,
    input word_t quat_w,
    input word_t world_x
);

    `AART_CHECK(a_rsp_hold, rsp_valid && rsp_stall |=> rsp_valid, "response dropped while stalled")

    `AART_HOLD(a_world_hold, world_x, "stalled response changed")

    // request side only backs up when the response side has been holding
    `AART_CHECK(a_stall_cause, $rose(req_stall) |-> $past(rsp_valid && rsp_stall), "stall without backpressure")

    `AART_CHECK(a_quat_range, rsp_valid |-> (quat_w <= 32'sd1073741824 && quat_w >= -32'sd1073741824), "quat_w out of range")

endmodule

bind angle_axis_rigid_transform aart_checker u_aart_checker (.*);

// File: bench/tb.sv
// self-checking testbench for angle_axis_rigid_transform: directed and random pose requests vs a predictor
module tb import aart_pkg::*;;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int NUM_REQUESTS = 1800;
    localparam int IDLE_LIMIT   = 5000;
    localparam int DRAIN_CYCLES = 120;
    localparam longint PI_VAL   = 64'sd3373259426;

    typedef struct {
        word_t ax, ay, az;
        word_t sx, sy, sz;
        word_t px, py, pz;
    } pose_req_t;

    class pose_scoreboard;
        result_t pending[$];
        int      fails;
        longint  atan_tbl[32] = '{
            843314856, 497837829, 263043836, 133525158, 67021686, 33543515,
            16775850, 8388437, 4194282, 2097149, 1048575, 524287, 262143,
            131071, 65535, 32767, 16383, 8191, 4095, 2047, 1023, 511, 255,
            127, 63, 31, 15, 8, 4, 2, 1, 0};

        function longint clip(longint v, longint lo, longint hi);
            return v < lo ? lo : (v > hi ? hi : v);
        endfunction

        function longint rnd30(longint v);
            return (v + 64'sd536870912) >>> 30;
        endfunction

        function longint unsigned int_sqrt(longint unsigned v);
            longint unsigned res, probe;
            res = 0;
            probe = 64'd1 << 62;
            while (probe > v)
                probe = probe >> 2;
            while (probe != 0)
            begin
                if (v >= res + probe)
                begin
                    v = v - (res + probe);
                    res = (res >> 1) + probe;
                end
                else
                    res = res >> 1;
                probe = probe >> 2;
            end
            return res;
        endfunction

        function void half_angle_cos_sin(longint theta, output longint c, output longint s);
            bit     flip;
            longint x, y, z, dx, dy;
            flip = 0;
            x = 652032874;
            y = 0;
            if (theta > PI_VAL)
                theta = theta - 2 * PI_VAL;
            if (theta > 64'sd1686629713)
            begin
                theta = theta - PI_VAL;
                flip = 1;
            end
            else if (theta < -64'sd1686629713)
            begin
                theta = theta + PI_VAL;
                flip = 1;
            end
            z = theta;
            for (int i = 0; i < CORDIC_STAGES_DEF; i++)
            begin
                dx = y >>> (i & 31);
                dy = x >>> (i & 31);
                if (z >= 0)
                begin
                    x = x - dx;
                    y = y + dy;
                    z = z - atan_tbl[i & 31];
                end
                else
                begin
                    x = x + dx;
                    y = y - dy;
                    z = z + atan_tbl[i & 31];
                end
            end
            if (flip)
            begin
                x = -x;
                y = -y;
            end
            c = clip(x, -(64'sd1 << 30), 64'sd1 << 30);
            s = clip(y, -(64'sd1 << 30), 64'sd1 << 30);
        endfunction

        function longint axis_share(longint r, longint sn, longint unsigned len);
            longint unsigned mr, ms, q;
            mr = r < 0 ? -r : r;
            ms = sn < 0 ? -sn : sn;
            q = (mr * ms + len / 2) / len;
            if (q > (64'd1 << 30))
                q = 64'd1 << 30;
            return ((r < 0) != (sn < 0)) ? -longint'(q) : longint'(q);
        endfunction

        function longint place_axis(longint m1, longint m2, longint m3,
                                    longint p1, longint p2, longint p3,
                                    longint self_c, longint shift);
            longint sum;
            sum = rnd30(m1 * p1) + rnd30(m2 * p2) + rnd30(m3 * p3);
            return clip(2 * sum + self_c + shift, -(64'sd1 << 31), (64'sd1 << 31) - 1);
        endfunction

        function result_t place_point(pose_req_t r);
            longint rx, ry, rz, px, py, pz, a, b, c, d, sn;
            longint t2, t3, t4, t5, t6, t7, t8, t9, t10;
            longint unsigned len;
            result_t o;
            rx = r.ax; ry = r.ay; rz = r.az;
            px = r.px; py = r.py; pz = r.pz;
            len = int_sqrt(longint'(rx * rx) + longint'(ry * ry) + longint'(rz * rz));
            half_angle_cos_sin(longint'(len * 2), a, sn);
            if (len == 0)
            begin
                b = 0; c = 0; d = 0;
            end
            else
            begin
                b = axis_share(rx, sn, len);
                c = axis_share(ry, sn, len);
                d = axis_share(rz, sn, len);
            end
            t2 = a * b; t3 = a * c; t4 = a * d;
            t5 = -(b * b); t6 = b * c; t7 = b * d;
            t8 = -(c * c); t9 = c * d; t10 = -(d * d);
            o.q.w = word_t'(a); o.q.x = word_t'(b);
            o.q.y = word_t'(c); o.q.z = word_t'(d);
            o.p.x = word_t'(place_axis(rnd30(t8 + t10), rnd30(t6 - t4), rnd30(t3 + t7),
                                       px, py, pz, px, longint'(r.sx)));
            o.p.y = word_t'(place_axis(rnd30(t4 + t6), rnd30(t5 + t10), rnd30(t9 - t2),
                                       px, py, pz, py, longint'(r.sy)));
            o.p.z = word_t'(place_axis(rnd30(t7 - t3), rnd30(t2 + t9), rnd30(t5 + t8),
                                       px, py, pz, pz, longint'(r.sz)));
            return o;
        endfunction

        function void note_request(pose_req_t r);
            pending.insert(pending.size(), place_point(r));
        endfunction

        function void check_response(result_t got);
            result_t exp_r;
            word_t   e[7], g[7];
            string   names[7] = '{"quat_w", "quat_x", "quat_y", "quat_z",
                                  "world_x", "world_y", "world_z"};
            if (pending.size() == 0)
            begin
                $error("response with no request outstanding");
                fails++;
                return;
            end
            exp_r = pending.pop_front();
            e = '{exp_r.q.w, exp_r.q.x, exp_r.q.y, exp_r.q.z, exp_r.p.x, exp_r.p.y, exp_r.p.z};
            g = '{got.q.w, got.q.x, got.q.y, got.q.z, got.p.x, got.p.y, got.p.z};
            for (int i = 0; i < 7; i++)
                if (e[i] !== g[i])
                begin
                    $error("%s mismatch: expected %0d, got %0d", names[i], e[i], g[i]);
                    fails++;
                end
        endfunction
    endclass

    logic  clk = 0;
    logic  rst_n = 0;
    logic  req_valid = 0;
    logic  req_stall;
    word_t axis_angle_x = 0, axis_angle_y = 0, axis_angle_z = 0;
    word_t shift_x = 0, shift_y = 0, shift_z = 0;
    word_t local_x = 0, local_y = 0, local_z = 0;
    logic  rsp_valid;
    logic  rsp_stall = 0;
    word_t quat_w, quat_x, quat_y, quat_z, world_x, world_y, world_z;

    pose_scoreboard sb = new();
    pose_req_t cur;
    int accepted = 0;
    int responses = 0;
    int idle_cycles = 0;

    angle_axis_rigid_transform dut (.*);

    always
    begin
        #1 clk = 1;
        #1 clk = 0;
    end

    function automatic word_t rand_sym(int unsigned m);
        return word_t'($urandom_range(0, 2 * m)) - word_t'(m);
    endfunction

    function automatic word_t rand_field(bit wide, int unsigned m);
        case ($urandom_range(0, 9))
            0: return 32'sh7fffffff;
            1: return 32'sh80000000;
            default: return wide ? word_t'($urandom()) : rand_sym(m);
        endcase
    endfunction

    function automatic pose_req_t make_request(int idx);
        pose_req_t r;
        word_t big = 32'sh7fffffff, low = 32'sh80000000;
        int unsigned pi_q28 = 843314857;
        bit wide;
        case (idx)
            0:  r = '{0, 0, 0, 0, 0, 0, 0, 0, 0};
            1:  r = '{0, 0, 0, 100, -100, 7, 65536, -65536, 123456};
            2:  r = '{big, big, big, big, big, big, big, big, big};
            3:  r = '{low, low, low, low, low, low, low, low, low};
            4:  r = '{big, 0, 0, 0, 0, 0, 0, big, low};
            5:  r = '{0, low, 0, 0, 0, 0, low, 0, big};
            6:  r = '{0, 0, 1, 0, 0, 0, 65536, 65536, 65536};
            7:  r = '{pi_q28, 0, 0, 0, 0, 0, 0, 65536, 0};
            8:  r = '{0, -pi_q28, 0, 0, 0, 0, 65536, 0, 0};
            9:  r = '{0, 0, pi_q28 / 2, 0, 0, 0, 65536, 0, 0};
            10: r = '{pi_q28 * 2, 0, 0, 5, 5, 5, 0, 0, 65536};
            11: r = '{-1, -1, -1, big, big, big, big, big, big};
            12: r = '{big, big, big, low, low, low, low, low, low};
            13: r = '{1, 0, 0, low, big, 0, 0, 0, 0};
            14: r = '{pi_q28 + 7, pi_q28, 0, 0, 0, 0, 12345678, -8765432, 1};
            15: r = '{0, 0, 0, big, low, 0, big, low, 0};
            default:
            begin
                wide = ($urandom_range(0, 3) == 0);
                case ($urandom_range(0, 3))
                    0: begin
                        r.ax = $urandom(); r.ay = $urandom(); r.az = $urandom();
                    end
                    1: begin
                        r.ax = rand_sym(pi_q28); r.ay = rand_sym(pi_q28);
                        r.az = rand_sym(pi_q28);
                    end
                    2: begin
                        // near a half turn, where the range fold switches
                        r.ax = word_t'(pi_q28) + rand_sym(4096);
                        r.ay = rand_sym(4096); r.az = rand_sym(4096);
                    end
                    default: begin
                        r.ax = rand_sym(64); r.ay = rand_sym(64); r.az = rand_sym(64);
                    end
                endcase
                r.sx = rand_field(wide, 1 << 24); r.sy = rand_field(wide, 1 << 24);
                r.sz = rand_field(wide, 1 << 24);
                r.px = rand_field(wide, 1 << 24); r.py = rand_field(wide, 1 << 24);
                r.pz = rand_field(wide, 1 << 24);
            end
        endcase
        return r;
    endfunction

    task automatic drive_requests();
        int issued = 0, burst = 0, gap = 0;
        while (accepted < NUM_REQUESTS)
        begin
            @(posedge clk);
            if (req_valid && !req_stall)
            begin
                sb.note_request(cur);
                accepted++;
            end
            if (!req_valid || !req_stall)
            begin
                if (issued == NUM_REQUESTS || gap > 0)
                begin
                    if (gap > 0)
                        gap--;
                    req_valid <= 0;
                end
                else
                begin
                    cur = make_request(issued);
                    issued++;
                    axis_angle_x <= cur.ax; axis_angle_y <= cur.ay; axis_angle_z <= cur.az;
                    shift_x <= cur.sx; shift_y <= cur.sy; shift_z <= cur.sz;
                    local_x <= cur.px; local_y <= cur.py; local_z <= cur.pz;
                    req_valid <= 1;
                    if (burst == 0)
                        burst = $urandom_range(1, 60);
                    burst--;
                    if (burst == 0)
                        gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
                end
            end
        end
    endtask

    // response side: changing stall patterns plus one long hold-off
    initial
    begin
        int mode = 0, mode_left = 0, hold_left = 0, phase = 0;
        bit held = 0;
        forever
        begin
            @(posedge clk);
            if (rsp_valid && !rsp_stall)
            begin
                sb.check_response('{'{quat_w, quat_x, quat_y, quat_z},
                                   '{world_x, world_y, world_z}});
                responses++;
            end
            if (!held && responses == 400)
            begin
                held = 1;
                hold_left = 400;
            end
            if (mode_left == 0)
            begin
                mode = $urandom_range(0, 3);
                mode_left = $urandom_range(50, 300);
            end
            mode_left--;
            phase++;
            if (hold_left > 0)
            begin
                hold_left--;
                rsp_stall <= 1;
            end
            else
                case (mode)
                    0: rsp_stall <= 0;
                    1: rsp_stall <= ($urandom_range(0, 9) < 3);
                    2: rsp_stall <= (phase % 5 < 2);
                    default: rsp_stall <= ($urandom_range(0, 9) < 8);
                endcase
        end
    end

    // watchdog on cycles with no handshake on either side
    initial
    begin
        forever
        begin
            @(posedge clk);
            if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("angle_axis_rigid_transform verification failed");
                $finish;
            end
        end
    end

    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1;
        drive_requests();
        while (sb.pending.size() > 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (sb.fails == 0 && sb.pending.size() == 0)
            $display("angle_axis_rigid_transform verification clean");
        else
            $display("angle_axis_rigid_transform verification failed");
        $finish;
    end
endmodule

// File: files.f
+incdir+sv
sv/aart_pkg.sv
sv/aart_delay.sv
sv/aart_isqrt.sv
sv/aart_cordic.sv
sv/aart_vdiv.sv
sv/aart_place.sv
sv/angle_axis_rigid_transform.sv
sv/aart_checker.sv
bench/tb.sv
